// ===== rtl/pattern_step_sequencer_macros.svh =====
// Assertion macros for the pattern step sequencer.
// Included by the controller and the datapath; no other dependencies.
`ifndef PATTERN_STEP_SEQUENCER_MACROS_SVH
`define PATTERN_STEP_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define PST_ASSERT_IMPL(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("pst assertion failed");
`define PST_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pst assertion failed");
`else
`define PST_ASSERT_IMPL(name, ck, rn, ante, cons)
`define PST_ASSERT_NEXT(name, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/pst_pkg.sv =====
// Shared types and constants of the pattern step sequencer.
// Used by pst_ctrl, pst_dp and pattern_step_sequencer; no dependencies.
package pst_pkg;

    localparam int CMD_W  = 2;
    localparam int SLOT_W = 5;
    localparam int STEP_W = 6;
    localparam int TONE_W = 16;
    localparam int REP_W  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 2'd0,
        CMD_WRITE      = 2'd1,
        CMD_ARM        = 2'd2,
        CMD_CLEAR_PERC = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH,
        ST_COPY
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic do_write;
        logic do_arm;
        logic do_clear_perc;
        logic walk_start;
        logic walk_issue;
        logic finish;
        logic copy_start;
        logic copy_issue;
    } ctl_t;

    typedef struct packed {
        logic clear_done;
        logic walk_last;
        logic copy_pend;
        logic copy_done;
    } sts_t;

endpackage

// ===== rtl/pst_ctrl.sv =====
// Controller state machine of the pattern step sequencer.
// Depends on pst_pkg and pattern_step_sequencer_macros.svh.
`include "pattern_step_sequencer_macros.svh"
module pst_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pst_pkg::CMD_W-1:0]  cmd,
    input  pst_pkg::sts_t              sts,
    output pst_pkg::ctl_t              ctl,
    output logic                       busy
);
    import pst_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start && cmd == CMD_TICK)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (sts.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = sts.copy_pend ? ST_COPY : ST_IDLE;
            end
            ST_COPY:
            begin
                if (sts.copy_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        busy              = (state_reg != ST_IDLE);
        accept            = (state_reg == ST_IDLE) && start;
        ctl               = '0;
        ctl.clear_wr      = (state_reg == ST_CLEAR);
        ctl.do_write      = accept && (cmd == CMD_WRITE);
        ctl.do_arm        = accept && (cmd == CMD_ARM);
        ctl.do_clear_perc = accept && (cmd == CMD_CLEAR_PERC);
        ctl.walk_start    = accept && (cmd == CMD_TICK);
        ctl.walk_issue    = (state_reg == ST_WALK);
        ctl.finish        = (state_reg == ST_FINISH);
        ctl.copy_start    = (state_reg == ST_FINISH) && sts.copy_pend;
        ctl.copy_issue    = (state_reg == ST_COPY) && !sts.copy_done;
    end

    `PST_ASSERT_NEXT(a_walk_flow, clk, rst_n, state_reg == ST_WALK, state_reg == ST_WALK || state_reg == ST_DRAIN)
    `PST_ASSERT_NEXT(a_finish_flow, clk, rst_n, state_reg == ST_FINISH, state_reg == ST_IDLE || state_reg == ST_COPY)
    `PST_ASSERT_NEXT(a_quick_cmd, clk, rst_n, !busy && start && cmd != CMD_TICK, !busy)

endmodule

// ===== rtl/pst_dp.sv =====
// Datapath of the pattern step sequencer: pattern memory, slot state,
// step position, result staging. Depends on pst_pkg and the macro header.
`include "pattern_step_sequencer_macros.svh"
module pst_dp #(
    parameter int TRACK_SLOTS   = 16,
    parameter int PATTERN_STEPS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pst_pkg::ctl_t               ctl,
    output pst_pkg::sts_t               sts,
    input  logic [pst_pkg::SLOT_W-1:0]  slot,
    input  logic [pst_pkg::STEP_W-1:0]  step,
    input  logic [pst_pkg::TONE_W-1:0]  tone,
    input  logic                        present,
    input  logic [pst_pkg::REP_W-1:0]   repeats,
    input  logic                        continuous,
    input  logic                        percussion,
    output logic                        strobe,
    output logic                        valid_res,
    output logic [pst_pkg::TONE_W-1:0]  tone_out,
    output logic [pst_pkg::SLOT_W-1:0]  from_slot,
    output logic                        is_percussion,
    output logic [pst_pkg::STEP_W-1:0]  play_step,
    output logic                        last
);
    import pst_pkg::*;

    localparam int DEPTH   = (TRACK_SLOTS + 2) * PATTERN_STEPS;
    localparam int AW      = $clog2(DEPTH);
    localparam int SW      = $clog2(TRACK_SLOTS + 1);
    localparam int SPW     = $clog2(PATTERN_STEPS + 1);
    localparam int SIW     = $clog2(PATTERN_STEPS);
    localparam int ENTRY_W = TONE_W + 1;

    localparam logic [AW-1:0]  PS_A      = AW'(PATTERN_STEPS);
    localparam logic [AW-1:0]  MEL_BASE  = AW'(TRACK_SLOTS * PATTERN_STEPS);
    localparam logic [AW-1:0]  PERM_BASE = AW'((TRACK_SLOTS + 1) * PATTERN_STEPS);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [SW-1:0]  MEL_IDX   = SW'(TRACK_SLOTS);
    localparam logic [SPW-1:0] PS_POS    = SPW'(PATTERN_STEPS);
    localparam logic [SPW-1:0] POS_ONE   = SPW'(1);

    logic [ENTRY_W-1:0] mem [0:DEPTH-1];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr;

    logic             active_reg [0:TRACK_SLOTS];
    logic [REP_W-1:0] rep_reg    [0:TRACK_SLOTS];
    logic             cont_reg   [0:TRACK_SLOTS];
    logic             kind_reg   [0:TRACK_SLOTS];

    logic [AW-1:0]     clr_cnt_reg;
    logic [SW-1:0]     walk_cnt_reg;
    logic [SPW-1:0]    pos_reg;
    logic [SPW-1:0]    copy_cnt_reg;
    logic              copy_pend_reg;
    logic              copy_wr_valid_reg;
    logic [SIW-1:0]    copy_wr_idx_reg;
    logic              eval_valid_reg;
    logic [SW-1:0]     eval_slot_reg;

    logic              pend_valid_reg;
    logic [TONE_W-1:0] pend_tone_reg;
    logic [SW-1:0]     pend_slot_reg;
    logic              pend_perc_reg;

    logic              strobe_reg;
    logic              strobe_next;
    logic              valid_res_reg;
    logic              valid_res_next;
    logic [TONE_W-1:0] tone_reg;
    logic [TONE_W-1:0] tone_next;
    logic [SW-1:0]     src_reg;
    logic [SW-1:0]     src_next;
    logic              perc_reg;
    logic              perc_next;
    logic              last_reg;
    logic              last_next;
    logic [SPW-1:0]    play_reg;

    logic              hit;
    logic              at_end;
    logic              write_ok;
    logic              arm_ok;
    logic [SW-1:0]     arm_idx;

    assign at_end   = (pos_reg == PS_POS);
    assign hit      = eval_valid_reg && active_reg[eval_slot_reg] && rd_data_reg[TONE_W];
    assign write_ok = (32'(slot) < TRACK_SLOTS + 2) && (step != '0)
                      && (32'(step) <= PATTERN_STEPS);
    assign arm_ok   = (32'(slot) <= TRACK_SLOTS);
    assign arm_idx  = SW'(slot);

    always_comb
    begin
        sts            = '0;
        sts.clear_done = (clr_cnt_reg == LAST_ADDR);
        sts.walk_last  = (walk_cnt_reg == MEL_IDX);
        sts.copy_pend  = copy_pend_reg;
        sts.copy_done  = (copy_cnt_reg == PS_POS);
    end

    // memory write and read port selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = '0;
        if (ctl.clear_wr)
        begin
            wr_en = 1'b1;
        end
        else if (copy_wr_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = MEL_BASE + AW'(copy_wr_idx_reg);
            wr_data = rd_data_reg;
        end
        else if (ctl.do_write && write_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(slot) * PS_A + AW'(step) - AW'(1);
            wr_data = present ? {1'b1, tone} : '0;
        end
    end

    always_comb
    begin
        if (ctl.copy_issue)
        begin
            rd_addr = PERM_BASE + AW'(copy_cnt_reg);
        end
        else
        begin
            rd_addr = AW'(walk_cnt_reg) * PS_A + AW'(pos_reg) - AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // sequencing counters and pipeline marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg       <= '0;
            walk_cnt_reg      <= '0;
            pos_reg           <= POS_ONE;
            copy_cnt_reg      <= '0;
            copy_wr_valid_reg <= 1'b0;
            copy_wr_idx_reg   <= '0;
            eval_valid_reg    <= 1'b0;
            eval_slot_reg     <= '0;
        end
        else
        begin
            if (ctl.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (ctl.walk_start)
            begin
                walk_cnt_reg <= '0;
            end
            else if (ctl.walk_issue)
            begin
                walk_cnt_reg <= walk_cnt_reg + SW'(1);
            end
            eval_valid_reg <= ctl.walk_issue;
            eval_slot_reg  <= walk_cnt_reg;
            if (ctl.finish)
            begin
                pos_reg <= at_end ? POS_ONE : pos_reg + SPW'(1);
            end
            if (ctl.copy_start)
            begin
                copy_cnt_reg <= '0;
            end
            else if (ctl.copy_issue)
            begin
                copy_cnt_reg <= copy_cnt_reg + SPW'(1);
            end
            copy_wr_valid_reg <= ctl.copy_issue;
            copy_wr_idx_reg   <= copy_cnt_reg[SIW-1:0];
        end
    end

    // slot state: arm, percussion clear, count down at the pattern end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= TRACK_SLOTS; i++)
            begin
                active_reg[i] <= 1'b0;
                rep_reg[i]    <= '0;
                cont_reg[i]   <= 1'b0;
                kind_reg[i]   <= 1'b0;
            end
            copy_pend_reg <= 1'b0;
        end
        else
        begin
            if (ctl.do_arm && arm_ok)
            begin
                active_reg[arm_idx] <= 1'b1;
                rep_reg[arm_idx]    <= repeats;
                cont_reg[arm_idx]   <= continuous;
                if (arm_idx != MEL_IDX)
                begin
                    kind_reg[arm_idx] <= percussion;
                end
            end
            if (ctl.do_clear_perc)
            begin
                for (int i = 0; i <= TRACK_SLOTS; i++)
                begin
                    if (kind_reg[i])
                    begin
                        active_reg[i] <= 1'b0;
                    end
                end
            end
            if (eval_valid_reg && at_end && active_reg[eval_slot_reg]
                && !cont_reg[eval_slot_reg])
            begin
                if (rep_reg[eval_slot_reg] == '0)
                begin
                    if (eval_slot_reg == MEL_IDX)
                    begin
                        cont_reg[eval_slot_reg] <= 1'b1;
                        copy_pend_reg           <= 1'b1;
                    end
                    else
                    begin
                        active_reg[eval_slot_reg] <= 1'b0;
                    end
                end
                else
                begin
                    rep_reg[eval_slot_reg] <= rep_reg[eval_slot_reg] - REP_W'(1);
                end
            end
            if (ctl.copy_start)
            begin
                copy_pend_reg <= 1'b0;
            end
        end
    end

    // hold one pending word so the final one can carry last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (ctl.walk_start || ctl.finish)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (hit)
        begin
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            pend_tone_reg <= rd_data_reg[TONE_W-1:0];
            pend_slot_reg <= eval_slot_reg;
            pend_perc_reg <= kind_reg[eval_slot_reg];
        end
    end

    always_comb
    begin
        strobe_next    = 1'b0;
        valid_res_next = pend_valid_reg;
        tone_next      = pend_tone_reg;
        src_next       = pend_slot_reg;
        perc_next      = pend_perc_reg;
        last_next      = 1'b0;
        if (ctl.finish)
        begin
            strobe_next = 1'b1;
            last_next   = 1'b1;
            if (!pend_valid_reg)
            begin
                tone_next = '0;
                src_next  = '0;
                perc_next = 1'b0;
            end
        end
        else if (hit && pend_valid_reg)
        begin
            strobe_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (strobe_next)
        begin
            valid_res_reg <= valid_res_next;
            tone_reg      <= tone_next;
            src_reg       <= src_next;
            perc_reg      <= perc_next;
            last_reg      <= last_next;
            play_reg      <= pos_reg;
        end
    end

    assign strobe        = strobe_reg;
    assign valid_res     = valid_res_reg;
    assign tone_out      = tone_reg;
    assign from_slot     = SLOT_W'(src_reg);
    assign is_percussion = perc_reg;
    assign play_step     = STEP_W'(play_reg);
    assign last          = last_reg;

    `PST_ASSERT_IMPL(a_eval_not_finish, clk, rst_n, eval_valid_reg, !ctl.finish)
    `PST_ASSERT_IMPL(a_empty_is_last, clk, rst_n, strobe_reg && !valid_res_reg, last_reg)
    `PST_ASSERT_IMPL(a_pos_range, clk, rst_n, 1'b1, pos_reg != '0 && pos_reg <= PS_POS)
    `PST_ASSERT_IMPL(a_copy_port_free, clk, rst_n, copy_wr_valid_reg, !ctl.do_write && !ctl.clear_wr)

endmodule

// ===== rtl/pattern_step_sequencer.sv =====
// Top level of the pattern step sequencer: controller plus datapath.
// Depends on pst_pkg, pst_ctrl and pst_dp.
//
//  channel  | handshake          | words
//  ---------+--------------------+-----------------------------------------
//  command  | start / busy       | cmd slot step tone present repeats
//           |                    | continuous percussion
//  result   | strobe, one cycle  | valid_res tone_out from_slot
//           |                    | is_percussion play_step last
//
// Step write, arm and percussion clear complete in idle; busy stays low.
// A tick holds busy for one memory read per slot walked, then one drain and
// one finish state; the last word is registered from the finish state.
// When the melody expires at the pattern end, a copy of the permanent
// pattern keeps busy high and goes through the memory's single write port.
// After reset a clearing pass over all (TRACK_SLOTS + 2) * PATTERN_STEPS
// entries empties the pattern memory with busy high. The receiver cannot stall.
module pattern_step_sequencer #(
    parameter int TRACK_SLOTS   = 16,
    parameter int PATTERN_STEPS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [pst_pkg::CMD_W-1:0]   cmd,
    input  logic [pst_pkg::SLOT_W-1:0]  slot,
    input  logic [pst_pkg::STEP_W-1:0]  step,
    input  logic [pst_pkg::TONE_W-1:0]  tone,
    input  logic                        present,
    input  logic [pst_pkg::REP_W-1:0]   repeats,
    input  logic                        continuous,
    input  logic                        percussion,
    output logic                        strobe,
    output logic                        valid_res,
    output logic [pst_pkg::TONE_W-1:0]  tone_out,
    output logic [pst_pkg::SLOT_W-1:0]  from_slot,
    output logic                        is_percussion,
    output logic [pst_pkg::STEP_W-1:0]  play_step,
    output logic                        last
);
    import pst_pkg::*;

    ctl_t ctl;
    sts_t sts;

    pst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    pst_dp #(
        .TRACK_SLOTS   (TRACK_SLOTS),
        .PATTERN_STEPS (PATTERN_STEPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .slot          (slot),
        .step          (step),
        .tone          (tone),
        .present       (present),
        .repeats       (repeats),
        .continuous    (continuous),
        .percussion    (percussion),
        .strobe        (strobe),
        .valid_res     (valid_res),
        .tone_out      (tone_out),
        .from_slot     (from_slot),
        .is_percussion (is_percussion),
        .play_step     (play_step),
        .last          (last)
    );

endmodule
